// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication check, held off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gssa_pkg.sv =====
package gssa_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int STACK_PAGES = 2;
    localparam int NUM_SLOTS   = 16;

    localparam int ADDR_W     = 32;
    localparam int OUT_SLOT_W = 6;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_BYTES = (STACK_PAGES + 1) * PAGE_BYTES;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [ADDR_W-1:0] SLOT_BYTES_A = ADDR_W'(SLOT_BYTES);

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_MAP_FAIL = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic exec;
    } t_ctl_cmd;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_busy;
    } t_dp_status;

    function automatic logic [ADDR_W-1:0] slot_offset(input int k);
        return ADDR_W'(k * SLOT_BYTES);
    endfunction

endpackage

// ===== sv/gssa_ctrl.sv =====
module gssa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gssa_pkg::t_ctl_cmd o_cmd
);

    gssa_pkg::t_state r_state;
    gssa_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_slot_open;

    assign w_slot_open = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gssa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gssa_pkg::S_EXEC;
                end
            end
            gssa_pkg::S_EXEC: begin
                if (w_slot_open) begin
                    n_state = gssa_pkg::S_IDLE;
                end
            end
            default: n_state = gssa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.latch_in = 1'b0;
        o_cmd.exec     = 1'b0;
        case (r_state)
            gssa_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            gssa_pkg::S_EXEC: begin
                o_cmd.exec = w_slot_open;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gssa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/gssa_dp.sv =====
module gssa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gssa_pkg::ADDR_W-1:0]     i_cfg_wdata,
    input  gssa_pkg::t_ctl_cmd              i_cmd,
    input  logic                            i_mode,
    input  logic [gssa_pkg::ADDR_W-1:0]     i_top_address,
    input  logic                            i_map_ok,
    output logic [gssa_pkg::ADDR_W-1:0]     o_result_top,
    output logic [gssa_pkg::OUT_SLOT_W-1:0] o_slot_index,
    output logic [gssa_pkg::STATUS_W-1:0]   o_status,
    output gssa_pkg::t_dp_status            o_status_grp
);

    logic [gssa_pkg::ADDR_W-1:0]     r_first_top;
    logic [gssa_pkg::NUM_SLOTS-1:0]  r_slot_busy;
    logic [gssa_pkg::NUM_SLOTS-1:0]  n_slot_busy;
    gssa_pkg::t_mode                 r_mode;
    logic [gssa_pkg::ADDR_W-1:0]     r_top;
    logic                            r_map_ok;
    logic [gssa_pkg::ADDR_W-1:0]     r_result_top;
    logic [gssa_pkg::OUT_SLOT_W-1:0] r_slot_index;
    gssa_pkg::t_status               r_status;
    logic [gssa_pkg::ADDR_W-1:0]     n_result_top;
    logic [gssa_pkg::OUT_SLOT_W-1:0] n_slot_index;
    gssa_pkg::t_status               n_status;

    logic [gssa_pkg::ADDR_W-1:0]     w_offset;
    logic [gssa_pkg::NUM_SLOTS-1:0]  w_hit;
    logic [gssa_pkg::SLOT_W-1:0]     w_hit_idx;
    logic                            w_hit_live;
    logic [gssa_pkg::SLOT_W-1:0]     w_free_idx;
    logic                            w_free_any;
    logic [gssa_pkg::ADDR_W-1:0]     w_alloc_ofs;

    always_comb begin
        w_offset   = r_top - r_first_top;
        w_hit      = '0;
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int k = gssa_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            w_hit[k] = (w_offset == gssa_pkg::slot_offset(k));
            if (w_hit[k]) begin
                w_hit_idx = gssa_pkg::SLOT_W'(k);
            end
            if (!r_slot_busy[k]) begin
                w_free_idx = gssa_pkg::SLOT_W'(k);
            end
        end
        w_hit_live  = |(w_hit & r_slot_busy);
        w_free_any  = ~&r_slot_busy;
        w_alloc_ofs = gssa_pkg::ADDR_W'(w_free_idx) * gssa_pkg::SLOT_BYTES_A;
    end

    always_comb begin
        n_slot_busy  = r_slot_busy;
        n_result_top = '0;
        n_slot_index = '0;
        n_status     = gssa_pkg::ST_OK;
        case (r_mode)
            gssa_pkg::MODE_ALLOC: begin
                if (!w_free_any) begin
                    n_status = gssa_pkg::ST_NO_SLOT;
                end else if (!r_map_ok) begin
                    n_status = gssa_pkg::ST_MAP_FAIL;
                end else begin
                    n_result_top            = r_first_top + w_alloc_ofs;
                    n_slot_index            = gssa_pkg::OUT_SLOT_W'(w_free_idx);
                    n_slot_busy[w_free_idx] = 1'b1;
                end
            end
            gssa_pkg::MODE_FREE: begin
                if (w_hit_live) begin
                    n_slot_index           = gssa_pkg::OUT_SLOT_W'(w_hit_idx);
                    n_slot_busy[w_hit_idx] = 1'b0;
                end else begin
                    n_status = gssa_pkg::ST_BAD_FREE;
                end
            end
            default: n_status = gssa_pkg::ST_BAD_FREE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_top <= gssa_pkg::SLOT_BYTES_A;
            r_slot_busy <= '0;
        end else begin
            if (i_cfg_we) begin
                r_first_top <= i_cfg_wdata + gssa_pkg::SLOT_BYTES_A;
            end
            if (i_cmd.exec) begin
                r_slot_busy <= n_slot_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode   <= gssa_pkg::t_mode'(i_mode);
            r_top    <= i_top_address;
            r_map_ok <= i_map_ok;
        end
        if (i_cmd.exec) begin
            r_result_top <= n_result_top;
            r_slot_index <= n_slot_index;
            r_status     <= n_status;
        end
    end

    assign o_result_top           = r_result_top;
    assign o_slot_index           = r_slot_index;
    assign o_status               = r_status;
    assign o_status_grp.slot_busy = r_slot_busy;

endmodule

// ===== sv/guarded_stack_slot_allocator_core.sv =====
// Guarded stack slot allocator: first-fit over a bitmap of fixed-size stack slots.
// Input stream (s_axis): tdata = top_address; tuser = {map_ok, mode}.
//   mode 0 allocates the lowest free slot (if map_ok), mode 1 frees a slot top.
// Output stream (m_axis): tdata = {status, slot_index, result_top}, one per input.
// Config: i_cfg_we / i_cfg_wdata write region_base; write only while idle.
// Output timing: after an input transfer the controller enters its execute state, and
//   m_axis_tvalid rises once the output register is free or being emptied.
// Requests do not overlap: the controller takes a request, then runs the slot search,
//   address compare and bitmap update in its execute state before it takes the next.
// An input is accepted while the previous result still waits in the output
//   register; if the receiver stalls, execution holds until that result is
//   taken, and s_axis_tready stays low meanwhile.
// Reset (synchronous, active low) clears the slot bitmap, sets region_base
//   to zero and drops any pending request and result.
`include "assert_macros.svh"

module guarded_stack_slot_allocator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gssa_pkg::ADDR_W-1:0]          i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] top_address
    input  logic [gssa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] mode, [1] map_ok
    input  logic [gssa_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] result_top, [37:32] slot_index, [39:38] status
    output logic [gssa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    gssa_pkg::t_ctl_cmd              w_cmd;
    gssa_pkg::t_dp_status            w_dp_status;
    logic [gssa_pkg::ADDR_W-1:0]     w_result_top;
    logic [gssa_pkg::OUT_SLOT_W-1:0] w_slot_index;
    logic [gssa_pkg::STATUS_W-1:0]   w_status;

    gssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    gssa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (w_cmd),
        .i_mode        (s_axis_tuser[0]),
        .i_top_address (s_axis_tdata),
        .i_map_ok      (s_axis_tuser[1]),
        .o_result_top  (w_result_top),
        .o_slot_index  (w_slot_index),
        .o_status      (w_status),
        .o_status_grp  (w_dp_status)
    );

    assign m_axis_tdata = {w_status, w_slot_index, w_result_top};

    `ASSERT_NEXT(a_accept_then_exec, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input transfer did not move the controller to execute")

    `ASSERT_IMPL(a_busy_only_on_exec, i_clk, i_rst_n, !$stable(w_dp_status.slot_busy),
        $past(w_cmd.exec), "slot bitmap changed outside an execute cycle")

    `ASSERT_IMPL(a_fail_is_zero, i_clk, i_rst_n,
        m_axis_tvalid && (w_status != gssa_pkg::ST_OK),
        (w_slot_index == '0) && (w_result_top == '0), "failed result carries nonzero fields")

endmodule

// ===== tb/sv/tb_guarded_stack_slot_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_guarded_stack_slot_allocator_core;

    localparam int STALL_LIMIT   = 2000;
    localparam int DIRECTED_ROWS = 15;

    typedef struct packed {
        gssa_pkg::t_status                    status;
        logic [gssa_pkg::OUT_SLOT_W-1:0]      slot;
        logic [gssa_pkg::ADDR_W-1:0]          top;
    } t_slot_result;

    typedef struct {
        gssa_pkg::t_mode                mode;
        logic [gssa_pkg::ADDR_W-1:0]    top;
        logic                           map_ok;
        int                             reps;
        bit                             typed;
        t_slot_result                   want;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [gssa_pkg::ADDR_W-1:0]      i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [gssa_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [gssa_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [gssa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    logic [gssa_pkg::NUM_SLOTS-1:0] busy_slots;
    logic [gssa_pkg::ADDR_W-1:0]    region_base_model;
    logic [gssa_pkg::ADDR_W-1:0]    stack_base;
    t_slot_result                   awaited_results[$];
    t_slot_result                   typed_result;
    t_slot_result                   got;
    t_slot_result                   want;
    bit                             typed_active;
    int                             src_idle_pct;
    int                             sink_idle_pct;
    bit                             long_hold_req;
    int                             hold_left;
    int                             stall_cycles;
    int                             errors;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{gssa_pkg::MODE_FREE,  32'h0000_0000, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_BAD_FREE, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_FREE,  32'hFFFF_FFFF, 1'b1, 1,  1'b1,
          '{gssa_pkg::ST_BAD_FREE, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_MAP_FAIL, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b1, 1,  1'b1,
          '{gssa_pkg::ST_OK,       6'd0,  32'h3000}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b1, 15, 1'b0,
          '{gssa_pkg::ST_OK,       6'd0,  32'h0}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b1, 1,  1'b1,
          '{gssa_pkg::ST_NO_SLOT,  6'd0,  32'h0}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_NO_SLOT,  6'd0,  32'h0}},
        '{gssa_pkg::MODE_FREE,  32'h0000_3000, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_OK,       6'd0,  32'h0}},
        '{gssa_pkg::MODE_FREE,  32'h0000_3000, 1'b1, 1,  1'b1,
          '{gssa_pkg::ST_BAD_FREE, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_FREE,  32'h0003_0000, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_OK,       6'd15, 32'h0}},
        '{gssa_pkg::MODE_FREE,  32'h0003_3000, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_BAD_FREE, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_FREE,  32'h0000_3001, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_BAD_FREE, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b0, 1,  1'b1,
          '{gssa_pkg::ST_MAP_FAIL, 6'd0,  32'h0}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b1, 1,  1'b1,
          '{gssa_pkg::ST_OK,       6'd0,  32'h3000}},
        '{gssa_pkg::MODE_ALLOC, 32'h0000_0000, 1'b1, 1,  1'b1,
          '{gssa_pkg::ST_OK,       6'd15, 32'h3_0000}}
    };

    guarded_stack_slot_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_slot_result apply_request(gssa_pkg::t_mode mode,
                                                   logic [gssa_pkg::ADDR_W-1:0] top,
                                                   logic map_ok);
        t_slot_result                res;
        logic [gssa_pkg::ADDR_W-1:0] offset;
        logic [gssa_pkg::ADDR_W-1:0] idx;
        bit                          found;
        res.top    = '0;
        res.slot   = '0;
        res.status = gssa_pkg::ST_NO_SLOT;
        found      = 1'b0;
        if (mode == gssa_pkg::MODE_ALLOC) begin
            for (int s = 0; s < gssa_pkg::NUM_SLOTS; s++) begin
                if (!found && !busy_slots[s]) begin
                    found = 1'b1;
                    if (map_ok) begin
                        busy_slots[s] = 1'b1;
                        res.top    = region_base_model
                                   + gssa_pkg::ADDR_W'((s + 1) * gssa_pkg::SLOT_BYTES);
                        res.slot   = gssa_pkg::OUT_SLOT_W'(s);
                        res.status = gssa_pkg::ST_OK;
                    end else begin
                        res.status = gssa_pkg::ST_MAP_FAIL;
                    end
                end
            end
        end else begin
            offset = top - region_base_model - gssa_pkg::SLOT_BYTES_A;
            idx    = offset / gssa_pkg::SLOT_BYTES_A;
            if ((offset % gssa_pkg::SLOT_BYTES_A) == 0 && idx < gssa_pkg::NUM_SLOTS
                    && busy_slots[idx[gssa_pkg::SLOT_W-1:0]]) begin
                busy_slots[idx[gssa_pkg::SLOT_W-1:0]] = 1'b0;
                res.slot   = gssa_pkg::OUT_SLOT_W'(idx);
                res.status = gssa_pkg::ST_OK;
            end else begin
                res.status = gssa_pkg::ST_BAD_FREE;
            end
        end
        return res;
    endfunction

    // predict on input transfers, check on output transfers, watch for hangs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            busy_slots        = '0;
            region_base_model = '0;
            stall_cycles      = 0;
        end else begin
            if (i_cfg_we)
                region_base_model = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_request(gssa_pkg::t_mode'(s_axis_tuser[0]), s_axis_tdata,
                                     s_axis_tuser[1]);
                if (typed_active)
                    want = typed_result;
                awaited_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_slot_result'(m_axis_tdata);
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.top !== want.top) begin
                        $display("%0t: result_top expected %h actual %h",
                                 $time, want.top, got.top);
                        errors++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot_index expected %0d actual %0d",
                                 $time, want.slot, got.slot);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // output side: random backpressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready = 1'b0;
                hold_left     = 299;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_request(gssa_pkg::t_mode mode, logic [gssa_pkg::ADDR_W-1:0] top,
                                logic map_ok, bit typed, t_slot_result expected);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        typed_active  = typed;
        typed_result  = expected;
        s_axis_tdata  = top;
        s_axis_tuser  = {map_ok, mode};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_region_base(logic [gssa_pkg::ADDR_W-1:0] value);
        while (awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        stack_base  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic run_random(int count, int alloc_pct);
        gssa_pkg::t_mode             mode;
        logic [gssa_pkg::ADDR_W-1:0] top;
        logic                        map_ok;
        int                          pick;
        int                          k;
        for (int n = 0; n < count; n++) begin
            pick   = $urandom_range(0, 99);
            top    = $urandom;
            map_ok = ($urandom_range(0, 9) != 0);
            if (pick < alloc_pct) begin
                mode = gssa_pkg::MODE_ALLOC;
            end else if (pick < 85) begin
                mode = gssa_pkg::MODE_FREE;
                top  = stack_base + gssa_pkg::ADDR_W'($urandom_range(1, gssa_pkg::NUM_SLOTS)
                                                      * gssa_pkg::SLOT_BYTES);
            end else if (pick < 93) begin
                mode = gssa_pkg::MODE_FREE;
                k    = $urandom_range(0, gssa_pkg::NUM_SLOTS + 1);
                top  = stack_base + gssa_pkg::ADDR_W'(k * gssa_pkg::SLOT_BYTES);
                case ($urandom_range(0, 2))
                    0: top = top + gssa_pkg::ADDR_W'(gssa_pkg::PAGE_BYTES);
                    1: top = top - 1;
                    default: ;
                endcase
            end else begin
                mode   = gssa_pkg::t_mode'($urandom_range(0, 1));
                map_ok = 1'($urandom_range(0, 1));
            end
            send_request(mode, top, map_ok, 1'b0, '0);
        end
        s_axis_tvalid = 1'b0;
        typed_active  = 1'b0;
    endtask

    initial begin
        errors        = 0;
        typed_active  = 1'b0;
        long_hold_req = 1'b0;
        stack_base    = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        src_idle_pct  = 10;
        sink_idle_pct = 61;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_region_base(32'h0000_0000);
        for (int r = 0; r < DIRECTED_ROWS; r++)
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_request(directed_rows[r].mode, directed_rows[r].top,
                             directed_rows[r].map_ok, directed_rows[r].typed,
                             directed_rows[r].want);
        s_axis_tvalid = 1'b0;
        typed_active  = 1'b0;

        write_region_base(32'hFFFF_F000);
        run_random(320, 45);

        src_idle_pct  = 61;
        sink_idle_pct = 10;
        write_region_base(32'hFFFF_FFFF);
        run_random(320, 30);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_region_base({20'($urandom_range(0, 20'hF_FFFF)), 12'h000});
        long_hold_req = 1'b1;
        run_random(310, 40);

        while (awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
